[hdl/ccs_pkg.sv]
// ----------------------------------------------------------------------------
// ccs_pkg
// Shared constants, types and character class helpers for the color code
// stripper.
// ----------------------------------------------------------------------------
package ccs_pkg;

    localparam int ResultsMax = 5;
    localparam int CntW       = $clog2(ResultsMax + 1);

    localparam logic [7:0] CharCaret = 8'h5E;
    localparam logic [7:0] CharExt   = 8'h78;
    localparam logic [7:0] CharDig0  = 8'h30;
    localparam logic [7:0] CharDig9  = 8'h39;
    localparam logic [7:0] CharLowA  = 8'h61;
    localparam logic [7:0] CharLowF  = 8'h66;
    localparam logic [7:0] CharUpA   = 8'h41;
    localparam logic [7:0] CharUpF   = 8'h46;

    // Match stage codes: how much of a candidate code is held back.
    localparam logic [2:0] StIdle  = 3'd0;
    localparam logic [2:0] StCaret = 3'd1;
    localparam logic [2:0] StExt   = 3'd2;
    localparam logic [2:0] StHex1  = 3'd3;
    localparam logic [2:0] StHex2  = 3'd4;

    // All results caused by one input character.
    typedef struct packed {
        logic [ResultsMax-1:0][7:0] data;
        logic [CntW-1:0]            cnt;
        logic                       last;
        logic                       bare;
    } ccs_batch_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CharDig0) && (c <= CharDig9);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || ((c >= CharLowA) && (c <= CharLowF))
            || ((c >= CharUpA) && (c <= CharUpF));
    endfunction

endpackage

[hdl/ccs_scan.sv]
// ----------------------------------------------------------------------------
// ccs_scan
// Match state and the single-pass scan of one character into a batch of
// up to five results.
// ----------------------------------------------------------------------------
module ccs_scan
    import ccs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output ccs_batch_t batch
);

    logic [2:0] stage_reg;
    logic [2:0] stage_next;
    logic [7:0] hex1_reg;
    logic [7:0] hex1_next;
    logic [7:0] hex2_reg;
    logic [7:0] hex2_next;

    always_comb
    begin
        logic            fail;
        logic            rescan;
        logic [CntW-1:0] n;
        fail       = 1'b0;
        rescan     = 1'b0;
        n          = '0;
        batch      = '0;
        stage_next = stage_reg;
        hex1_next  = hex1_reg;
        hex2_next  = hex2_reg;

        case (stage_reg)
            StCaret:
            begin
                if (is_digit(in_byte))
                    stage_next = StIdle;
                else if (in_byte == CharExt)
                    stage_next = StExt;
                else
                    fail = 1'b1;
            end
            StExt:
            begin
                if (is_hex(in_byte))
                begin
                    hex1_next  = in_byte;
                    stage_next = StHex1;
                end
                else
                    fail = 1'b1;
            end
            StHex1:
            begin
                if (is_hex(in_byte))
                begin
                    hex2_next  = in_byte;
                    stage_next = StHex2;
                end
                else
                    fail = 1'b1;
            end
            StHex2:
            begin
                if (is_hex(in_byte))
                    stage_next = StIdle;
                else
                    fail = 1'b1;
            end
            default:
                rescan = 1'b1;
        endcase

        // A broken candidate releases its held bytes, then the character is
        // scanned again from the idle stage.
        if (fail)
        begin
            batch.data[n] = CharCaret;
            n = n + 1'b1;
            if (stage_reg >= StExt)
            begin
                batch.data[n] = CharExt;
                n = n + 1'b1;
            end
            if (stage_reg >= StHex1)
            begin
                batch.data[n] = hex1_reg;
                n = n + 1'b1;
            end
            if (stage_reg >= StHex2)
            begin
                batch.data[n] = hex2_reg;
                n = n + 1'b1;
            end
            rescan = 1'b1;
        end

        if (rescan)
        begin
            if (in_byte == CharCaret)
                stage_next = StCaret;
            else
            begin
                batch.data[n] = in_byte;
                n = n + 1'b1;
                stage_next = StIdle;
            end
        end

        // The end of the string flushes whatever is still held.
        if (in_last)
        begin
            if (stage_next >= StCaret && stage_next <= StHex2)
            begin
                batch.data[n] = CharCaret;
                n = n + 1'b1;
            end
            if (stage_next >= StExt && stage_next <= StHex2)
            begin
                batch.data[n] = CharExt;
                n = n + 1'b1;
            end
            if (stage_next >= StHex1 && stage_next <= StHex2)
            begin
                batch.data[n] = hex1_next;
                n = n + 1'b1;
            end
            if (stage_next == StHex2)
            begin
                batch.data[n] = hex2_next;
                n = n + 1'b1;
            end
            stage_next = StIdle;
        end

        batch.last = in_last;
        batch.bare = in_last && (n == '0);
        if (batch.bare)
            n = n + 1'b1;
        batch.cnt = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= StIdle;
            hex1_reg  <= '0;
            hex2_reg  <= '0;
        end
        else if (advance)
        begin
            stage_reg <= stage_next;
            hex1_reg  <= hex1_next;
            hex2_reg  <= hex2_next;
        end
    end

endmodule

[hdl/ccs_outbuf.sv]
// ----------------------------------------------------------------------------
// ccs_outbuf
// Result register that holds one batch and hands it out one entry per
// transaction on the master side.
// ----------------------------------------------------------------------------
module ccs_outbuf
    import ccs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  ccs_batch_t batch,
    output logic       can_load,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic [0:0] m_tuser,
    output logic       m_tlast
);

    logic [ResultsMax-1:0][7:0] data_reg;
    logic [CntW-1:0]            cnt_reg;
    logic [CntW-1:0]            idx_reg;
    logic                       last_reg;
    logic                       bare_reg;
    logic                       final_entry;

    assign final_entry = (idx_reg == cnt_reg - 1'b1);
    assign m_tvalid    = (idx_reg != cnt_reg);
    assign m_tdata     = data_reg[idx_reg];
    assign m_tuser     = ~bare_reg;
    assign m_tlast     = last_reg && final_entry;
    // A new batch may land in the same cycle as the final entry leaves.
    assign can_load    = !m_tvalid || (m_tready && final_entry);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else if (load)
        begin
            cnt_reg <= batch.cnt;
            idx_reg <= '0;
        end
        else if (m_tvalid && m_tready)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= batch.data;
            last_reg <= batch.last;
            bare_reg <= batch.bare;
        end
    end

endmodule

[hdl/color_code_stripper.sv]
// ----------------------------------------------------------------------------
// color_code_stripper
// Streams a text string through and removes color codes.
// ----------------------------------------------------------------------------
// A character is taken into an input register, scanned combinationally against
// the pending code and its results (zero to five bytes) are loaded into a
// result register that drains one byte per transaction. Characters that yield
// at most one result flow at one character per clock while m_tready is held
// high; a character that releases a broken code or ends the string with held
// bytes occupies the output for one transaction per result byte, up to five.
// The final result of a string carries tlast; when the string ends with nothing
// to emit, a bare end marker with tuser clear and tdata zero is sent.
module color_code_stripper
    import ccs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // in_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [0:0] m_tuser,   // [0] byte_valid
    output logic       m_tlast    // out_last
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       can_load;
    logic       load;
    ccs_batch_t batch;

    assign load     = in_valid_reg && can_load;
    assign s_tready = !in_valid_reg || load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    ccs_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (load),
        .in_byte (in_byte_reg),
        .in_last (in_last_reg),
        .batch   (batch)
    );

    ccs_outbuf u_outbuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .batch    (batch),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

[hdl/ccs_checker.sv]
// ----------------------------------------------------------------------------
// ccs_checker
// Port-level checks for the color code stripper, bound to the top level.
// ----------------------------------------------------------------------------
module ccs_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [0:0] m_tuser,
    input logic       m_tlast
);

    // A stalled result holds still.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tuser) && $stable(m_tlast))
        else $error("result changed while stalled");

    // A result without a character only ever marks the end of a string.
    a_bare_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tlast)
        else $error("bare result without end mark");

    // The bare end marker carries a zero byte.
    a_bare_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == 8'h00)
        else $error("bare result with nonzero byte");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("result pending after reset");

endmodule

bind color_code_stripper ccs_checker u_ccs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

[tb/tb_color_code_stripper.sv]
// ----------------------------------------------------------------------------
// tb_color_code_stripper
// Self-checking bench for the color code stripper. Text strings, made mostly
// of valid, broken and partial color codes mixed with plain characters, are
// streamed in with random gaps and output stalls. A scoreboard predicts the
// stripped bytes and end markers and compares every output transaction.
// ----------------------------------------------------------------------------
module tb_color_code_stripper;

    import ccs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] ch;
        logic       has_char;
        logic       last;
    } strip_result_t;

    class strip_scoreboard;

        strip_result_t expected_q[$];
        strip_result_t batch[$];
        logic [2:0]    stage;
        logic [7:0]    hex_a;
        logic [7:0]    hex_b;
        int            mismatches;

        function new();
            stage      = StIdle;
            hex_a      = 8'h00;
            hex_b      = 8'h00;
            mismatches = 0;
        endfunction

        function bit is_dec(logic [7:0] c);
            return c >= CharDig0 && c <= CharDig9;
        endfunction

        function bit is_hexch(logic [7:0] c);
            return is_dec(c) || (c >= CharLowA && c <= CharLowF)
                || (c >= CharUpA && c <= CharUpF);
        endfunction

        function void push_char(logic [7:0] c);
            batch.push_back('{ch: c, has_char: 1'b1, last: 1'b0});
        endfunction

        // Give back every byte of a pending code that did not complete.
        function void release_held();
            if (stage >= StCaret && stage <= StHex2)
            begin
                push_char(CharCaret);
                if (stage >= StExt)
                    push_char(CharExt);
                if (stage >= StHex1)
                    push_char(hex_a);
                if (stage >= StHex2)
                    push_char(hex_b);
            end
            stage = StIdle;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_input(logic [7:0] c, logic is_last);
            bit            done;
            strip_result_t tail;
            done = 1'b0;
            batch.delete();
            // A byte that breaks a candidate code gets a second look from idle.
            for (int pass = 0; pass < 2 && !done; pass++)
            begin
                case (stage)
                    StCaret:
                    begin
                        if (is_dec(c))
                        begin
                            stage = StIdle;
                            done  = 1'b1;
                        end
                        else if (c == CharExt)
                        begin
                            stage = StExt;
                            done  = 1'b1;
                        end
                    end
                    StExt:
                    begin
                        if (is_hexch(c))
                        begin
                            hex_a = c;
                            stage = StHex1;
                            done  = 1'b1;
                        end
                    end
                    StHex1:
                    begin
                        if (is_hexch(c))
                        begin
                            hex_b = c;
                            stage = StHex2;
                            done  = 1'b1;
                        end
                    end
                    StHex2:
                    begin
                        if (is_hexch(c))
                        begin
                            stage = StIdle;
                            done  = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (c == CharCaret)
                            stage = StCaret;
                        else
                        begin
                            stage = StIdle;
                            push_char(c);
                        end
                        done = 1'b1;
                    end
                endcase
                if (!done)
                    release_held();
            end
            if (is_last)
            begin
                release_held();
                if (batch.size() == 0)
                    batch.push_back('{ch: 8'h00, has_char: 1'b0, last: 1'b1});
                else
                begin
                    tail      = batch.pop_back();
                    tail.last = 1'b1;
                    batch.push_back(tail);
                end
            end
            foreach (batch[i])
                expected_q.push_back(batch[i]);
        endfunction

        function void check_result(logic [7:0] ch, logic has_char, logic is_last);
            strip_result_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%t: unexpected output byte %h valid %b last %b",
                             $realtime, ch, has_char, is_last);
            end
            else
            begin
                want = expected_q.pop_front();
                if (want.ch !== ch || want.has_char !== has_char || want.last !== is_last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%t: expected byte %h valid %b last %b, got %h %b %b",
                                 $realtime, want.ch, want.has_char, want.last,
                                 ch, has_char, is_last);
                end
            end
        endfunction

    endclass

    logic       clk;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [0:0] m_tuser;
    logic       m_tlast;

    strip_scoreboard sb = new();

    bit tx_quiet  = 1'b0;
    bit rx_quiet  = 1'b0;
    int hold_req  = 0;
    int sent_cnt  = 0;

    color_code_stripper dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_input(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser[0], m_tlast);
        end
    end

    // Output side: random stalls per transaction, plus a long hold on request.
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            if (hold_req > 0)
            begin
                m_tready <= 1'b0;
                repeat (hold_req) @(posedge clk);
                hold_req = 0;
            end
            stall = rx_quiet ? 0 : $urandom_range(0, 14);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    task automatic send_char(input logic [7:0] ch, input logic is_last);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= is_last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent_cnt++;
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++)
            send_char(text[i], i == text.len() - 1);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == CharCaret);
        return c;
    endfunction

    function automatic logic [7:0] hex_char();
        int k;
        k = $urandom_range(0, 21);
        if (k < 10)
            return CharDig0 + 8'(k);
        else if (k < 16)
            return CharLowA + 8'(k - 10);
        else
            return CharUpA + 8'(k - 16);
    endfunction

    // Build a string from tokens, mixing codes, broken codes and plain bytes, and send it.
    task automatic send_random_text();
        logic [7:0] text[$];
        int         tokens;
        int         depth;
        tokens = $urandom_range(1, 8);
        for (int t = 0; t < tokens; t++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: text.push_back(plain_char());
                3, 4:
                begin
                    text.push_back(CharCaret);
                    text.push_back(CharDig0 + 8'($urandom_range(0, 9)));
                end
                5, 6:
                begin
                    text.push_back(CharCaret);
                    text.push_back(CharExt);
                    repeat (3) text.push_back(hex_char());
                end
                7:
                begin
                    // A prefix of a long code, followed by an arbitrary byte.
                    depth = $urandom_range(1, 4);
                    text.push_back(CharCaret);
                    if (depth >= 2)
                        text.push_back(CharExt);
                    for (int h = 2; h < depth; h++)
                        text.push_back(hex_char());
                    text.push_back(8'($urandom_range(1, 255)));
                end
                8: text.push_back(CharCaret);
                default: text.push_back(8'($urandom_range(1, 255)));
            endcase
        end
        foreach (text[i])
            send_char(text[i], i == text.size() - 1);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("^5");
        send_text("^xA0f");
        send_text("^x12\377");
        send_text("^^5a");
        send_text("^xg");
        send_text("^");
        send_text("^x1^");
        send_text("\001");
        wait_drained();

        while (sent_cnt < 150)
            send_random_text();

        // Long output hold while the input keeps pushing.
        wait_drained();
        tx_quiet = 1'b1;
        hold_req = 300;
        while (sent_cnt < 210)
            send_random_text();

        wait_drained();
        rx_quiet = 1'b1;
        while (sent_cnt < 290)
            send_random_text();

        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        while (sent_cnt < 380)
            send_random_text();

        wait_drained();
        repeat (20) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
